@@ rtl/core/bls_pkg.sv @@
// ---------------------------------------------------------------------------
// bls_pkg: shared types and constants of the ball load sequencer
// Transaction payload structs, register reset values and fixed commands.
// ---------------------------------------------------------------------------
package bls_pkg;

  // input transaction, one control tick
  typedef struct packed {
    logic               load_request;
    logic signed [15:0] pitch_cmd_in;
    logic               spin_cmd_in;
    logic signed [15:0] speed_cmd_in;
    logic        [31:0] now_us;
    logic signed [15:0] pitch_motor_angle;
    logic signed [15:0] spin_motor_angle;
  } in_t;

  // result transaction
  typedef struct packed {
    logic signed [15:0] pitch_cmd_out;
    logic               spin_cmd_out;
    logic signed [15:0] speed_cmd_out;
    logic               gripper_drive;
    logic               gripper_open;
    logic        [2:0]  sequence_step;
  } out_t;

  // register reset values
  localparam logic        [31:0] PITCH_HOME_TIMEOUT_RST = 32'd4000000;
  localparam logic        [31:0] SPIN_REACH_TIMEOUT_RST = 32'd4000000;
  localparam logic        [31:0] SETTLE_DELAY_RST       = 32'd100000;
  localparam logic        [31:0] REVERSE_DURATION_RST   = 32'd1500000;
  localparam logic        [31:0] FINAL_DELAY_RST        = 32'd600000;
  localparam logic signed [15:0] PITCH_HOME_LIMIT_RST   = 16'sd100;
  localparam logic signed [15:0] SPIN_REACHED_ANGLE_RST = 16'sd450;

  // fixed commands while the sequence runs
  localparam logic signed [15:0] HELD_PITCH    = 16'sd0;
  localparam logic signed [15:0] REVERSE_SPEED = -16'sd3500;
  localparam logic signed [15:0] STOP_SPEED    = 16'sd0;
  localparam logic signed [15:0] FINAL_PITCH   = 16'sd600;

endpackage

@@ rtl/core/ball_load_sequencer.sv @@
// ---------------------------------------------------------------------------
// ball_load_sequencer: six-step ball loader sequence
// Overrides pitch, spin and belt commands while loading, drives the gripper.
// ---------------------------------------------------------------------------
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  input     | in_valid, in_ready, in_data          | in
//  result    | out_valid, out_ready, out_data       | out
//  registers | psel, penable, pwrite, paddr, pwdata | in
//            | prdata, pready                       | out
//
// One transaction per cycle while in_ready is high; a result appears in the
// output register in the cycle after its input transaction is accepted.
// Every step of the cascade is evaluated in the cycle of acceptance: the five time
// compares against the stored step start time run in parallel.
// in_ready is high whenever the output register is empty or being emptied.
// Synchronous reset returns to idle and restores the register defaults.
// ---------------------------------------------------------------------------
module ball_load_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bls_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bls_pkg::out_t       out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic         [4:0]  paddr,
  input  logic         [31:0] pwdata,
  output logic         [31:0] prdata,
  output logic                pready
);

  // step codes
  localparam logic [2:0] STEP_IDLE    = 3'd0;
  localparam logic [2:0] STEP_HOME    = 3'd1;
  localparam logic [2:0] STEP_SPIN    = 3'd2;
  localparam logic [2:0] STEP_SETTLE  = 3'd3;
  localparam logic [2:0] STEP_REVERSE = 3'd4;
  localparam logic [2:0] STEP_FINAL   = 3'd5;

  // register indexes
  localparam logic [2:0] REG_PITCH_HOME_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_SPIN_REACH_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_SETTLE_DELAY       = 3'd2;
  localparam logic [2:0] REG_REVERSE_DURATION   = 3'd3;
  localparam logic [2:0] REG_FINAL_DELAY        = 3'd4;
  localparam logic [2:0] REG_PITCH_HOME_LIMIT   = 3'd5;
  localparam logic [2:0] REG_SPIN_REACHED_ANGLE = 3'd6;

  logic        [31:0] pitch_home_timeout;
  logic        [31:0] spin_reach_timeout;
  logic        [31:0] settle_delay;
  logic        [31:0] reverse_duration;
  logic        [31:0] final_delay;
  logic signed [15:0] pitch_home_limit;
  logic signed [15:0] spin_reached_angle;

  logic [2:0]  step;
  logic [31:0] step_start_time;
  logic        held_spin;
  logic        belt_reversing;
  logic        held_gripper_open;

  logic [2:0]  step_next;
  logic [31:0] step_start_time_next;
  logic        held_spin_next;
  logic        belt_reversing_next;
  logic        held_gripper_open_next;
  bls_pkg::out_t result_next;

  logic        in_fire;
  logic        reg_write;
  logic [2:0]  reg_index;
  logic [31:0] elapsed;
  logic        home_timeout_hit;
  logic        spin_timeout_hit;
  logic        settle_done;
  logic        reverse_done;
  logic        final_done;
  logic        pitch_home;
  logic        spin_reached;
  logic signed [16:0] neg_pitch;

  // handshakes
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign reg_write = psel && penable && pwrite;
  assign reg_index = paddr[4:2];
  assign pready    = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_home_timeout <= bls_pkg::PITCH_HOME_TIMEOUT_RST;
      spin_reach_timeout <= bls_pkg::SPIN_REACH_TIMEOUT_RST;
      settle_delay       <= bls_pkg::SETTLE_DELAY_RST;
      reverse_duration   <= bls_pkg::REVERSE_DURATION_RST;
      final_delay        <= bls_pkg::FINAL_DELAY_RST;
      pitch_home_limit   <= bls_pkg::PITCH_HOME_LIMIT_RST;
      spin_reached_angle <= bls_pkg::SPIN_REACHED_ANGLE_RST;
    end else if (reg_write) begin
      case (reg_index)
        REG_PITCH_HOME_TIMEOUT: pitch_home_timeout <= pwdata;
        REG_SPIN_REACH_TIMEOUT: spin_reach_timeout <= pwdata;
        REG_SETTLE_DELAY:       settle_delay       <= pwdata;
        REG_REVERSE_DURATION:   reverse_duration   <= pwdata;
        REG_FINAL_DELAY:        final_delay        <= pwdata;
        REG_PITCH_HOME_LIMIT:   pitch_home_limit   <= pwdata[15:0];
        REG_SPIN_REACHED_ANGLE: spin_reached_angle <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_index)
      REG_PITCH_HOME_TIMEOUT: prdata = pitch_home_timeout;
      REG_SPIN_REACH_TIMEOUT: prdata = spin_reach_timeout;
      REG_SETTLE_DELAY:       prdata = settle_delay;
      REG_REVERSE_DURATION:   prdata = reverse_duration;
      REG_FINAL_DELAY:        prdata = final_delay;
      REG_PITCH_HOME_LIMIT:   prdata = {{16{pitch_home_limit[15]}}, pitch_home_limit};
      REG_SPIN_REACHED_ANGLE: prdata = {{16{spin_reached_angle[15]}}, spin_reached_angle};
      default:                prdata = 32'd0;
    endcase
  end

  // time and angle compares; the time compares run against the stored start time
  assign elapsed          = in_data.now_us - step_start_time;
  assign home_timeout_hit = elapsed > pitch_home_timeout;
  assign spin_timeout_hit = elapsed > spin_reach_timeout;
  assign settle_done      = elapsed >= settle_delay;
  assign reverse_done     = elapsed >= reverse_duration;
  assign final_done       = elapsed >= final_delay;
  assign neg_pitch        = -{in_data.pitch_motor_angle[15], in_data.pitch_motor_angle};
  assign pitch_home       = neg_pitch < $signed({pitch_home_limit[15], pitch_home_limit});
  assign spin_reached     = in_data.spin_motor_angle > spin_reached_angle;

  // step cascade; fresh marks a start time restarted this tick (elapsed zero)
  always_comb begin
    logic fresh;
    fresh                  = 1'b0;
    step_next              = step;
    held_spin_next         = held_spin;
    belt_reversing_next    = belt_reversing;
    held_gripper_open_next = held_gripper_open;

    result_next.pitch_cmd_out = in_data.pitch_cmd_in;
    result_next.spin_cmd_out  = in_data.spin_cmd_in;
    result_next.speed_cmd_out = in_data.speed_cmd_in;
    result_next.gripper_drive = 1'b0;
    result_next.gripper_open  = 1'b0;

    // idle passes the caller through, busy steps hold their own commands
    if (step == STEP_IDLE) begin
      held_spin_next = in_data.spin_cmd_in;
      if (in_data.load_request) begin
        fresh          = 1'b1;
        held_spin_next = 1'b0;
        step_next      = STEP_HOME;
      end
    end else begin
      result_next.gripper_drive = 1'b1;
      result_next.gripper_open  = held_gripper_open;
      result_next.pitch_cmd_out = bls_pkg::HELD_PITCH;
      result_next.speed_cmd_out = belt_reversing ? bls_pkg::REVERSE_SPEED
                                                 : bls_pkg::STOP_SPEED;
      result_next.spin_cmd_out  = held_spin;
    end

    // wait for pitch home
    if (step_next == STEP_HOME) begin
      if (pitch_home) begin
        fresh          = 1'b1;
        held_spin_next = 1'b1;
        step_next      = STEP_SPIN;
      end else if (!fresh && home_timeout_hit) begin
        step_next = STEP_IDLE;
      end
    end

    // wait for spin angle
    if (step_next == STEP_SPIN) begin
      if (spin_reached) begin
        fresh     = 1'b1;
        step_next = STEP_SETTLE;
      end
      if (!fresh && spin_timeout_hit) begin
        step_next = STEP_IDLE;
      end
    end

    // settle, then reverse the belt with the gripper open
    if (step_next == STEP_SETTLE) begin
      if (fresh ? (settle_delay == 32'd0) : settle_done) begin
        fresh                  = 1'b1;
        belt_reversing_next    = 1'b1;
        held_gripper_open_next = 1'b1;
        step_next              = STEP_REVERSE;
      end
    end

    // stop the belt and close the gripper
    if (step_next == STEP_REVERSE) begin
      if (fresh ? (reverse_duration == 32'd0) : reverse_done) begin
        fresh                  = 1'b1;
        belt_reversing_next    = 1'b0;
        held_gripper_open_next = 1'b0;
        step_next              = STEP_FINAL;
      end
    end

    // final pitch command and back to idle
    if (step_next == STEP_FINAL) begin
      if (fresh ? (final_delay == 32'd0) : final_done) begin
        held_spin_next            = 1'b1;
        result_next.pitch_cmd_out = bls_pkg::FINAL_PITCH;
        step_next                 = STEP_IDLE;
      end
    end

    step_start_time_next      = fresh ? in_data.now_us : step_start_time;
    result_next.sequence_step = step_next;
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      step              <= STEP_IDLE;
      step_start_time   <= 32'd0;
      held_spin         <= 1'b0;
      belt_reversing    <= 1'b0;
      held_gripper_open <= 1'b0;
    end else if (in_fire) begin
      step              <= step_next;
      step_start_time   <= step_start_time_next;
      held_spin         <= held_spin_next;
      belt_reversing    <= belt_reversing_next;
      held_gripper_open <= held_gripper_open_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

  // checks
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    in_fire && step == STEP_IDLE && !in_data.load_request |=> step == STEP_IDLE)
    else $error("idle left without a load request");

  a_step_reported: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_data.sequence_step == step)
    else $error("reported step differs from sequence state");

  a_busy_drives: assert property (@(posedge clk) disable iff (rst)
    in_fire && step != STEP_IDLE |=> out_data.gripper_drive)
    else $error("gripper not driven during a busy step");

  a_reverse_step: assert property (@(posedge clk) disable iff (rst)
    belt_reversing |-> step == STEP_REVERSE && held_gripper_open)
    else $error("belt reversing outside the reverse step");

endmodule

@@ verif/bls_tb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bls_tb_pkg: verification codes for the ball load sequencer
// Register indexes of the configuration port and the loader step encoding.
// ---------------------------------------------------------------------------
package bls_tb_pkg;

  // register index, byte address is four times the index
  typedef enum logic [2:0] {
    REG_PITCH_HOME_TIMEOUT,
    REG_SPIN_REACH_TIMEOUT,
    REG_SETTLE_DELAY,
    REG_REVERSE_DURATION,
    REG_FINAL_DELAY,
    REG_PITCH_HOME_LIMIT,
    REG_SPIN_REACHED_ANGLE
  } reg_idx_e;

  // loader steps as reported in sequence_step
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_PITCH_HOME,
    STEP_SPIN_REACH,
    STEP_SETTLE,
    STEP_REVERSE,
    STEP_FINAL
  } seq_step_e;

endpackage

@@ verif/bls_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bls_checker: result checker for the ball load sequencer
// Snoops register writes, steps its own loader model on every accepted
// input transaction and compares each result transaction field by field.
// ---------------------------------------------------------------------------
module bls_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  bls_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  bls_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  output int            fail_count,
  output int            pending,
  output int            ticks_checked,
  output int            loads_done,
  output int            loads_aborted
);
  import bls_pkg::*;
  import bls_tb_pkg::*;

  localparam int PRINT_LIMIT = 40;

  // register copy
  logic        [31:0] home_timeout;
  logic        [31:0] reach_timeout;
  logic        [31:0] settle_us;
  logic        [31:0] reverse_us;
  logic        [31:0] final_us;
  logic signed [15:0] home_limit;
  logic signed [15:0] reach_angle;

  // loader state copy
  seq_step_e   seq_step;
  logic [31:0] step_t0;
  logic        spin_hold;
  logic        belt_rev;
  logic        grip_hold;

  out_t expected_cmds[$];

  // one control tick of the loader, returns the commands it should drive
  function automatic out_t advance_loader(input in_t t);
    out_t        r;
    logic [31:0] now;
    int          pitch_ang;
    int          spin_ang;
    now       = t.now_us;
    pitch_ang = int'(t.pitch_motor_angle);
    spin_ang  = int'(t.spin_motor_angle);
    r.pitch_cmd_out = t.pitch_cmd_in;
    r.spin_cmd_out  = t.spin_cmd_in;
    r.speed_cmd_out = t.speed_cmd_in;
    r.gripper_drive = 1'b0;
    r.gripper_open  = 1'b0;
    // outputs are captured before the cascade runs
    if (seq_step == STEP_IDLE) begin
      spin_hold = t.spin_cmd_in;
      if (t.load_request) begin
        step_t0   = now;
        spin_hold = 1'b0;
        seq_step  = STEP_PITCH_HOME;
      end
    end else begin
      r.gripper_drive = 1'b1;
      r.gripper_open  = grip_hold;
      r.pitch_cmd_out = HELD_PITCH;
      r.speed_cmd_out = belt_rev ? REVERSE_SPEED : STOP_SPEED;
      r.spin_cmd_out  = spin_hold;
    end
    // wait for pitch home, abort on timeout
    if (seq_step == STEP_PITCH_HOME) begin
      if (-pitch_ang < int'(home_limit)) begin
        step_t0   = now;
        spin_hold = 1'b1;
        seq_step  = STEP_SPIN_REACH;
      end else if (32'(now - step_t0) > home_timeout) begin
        seq_step = STEP_IDLE;
        loads_aborted++;
      end
    end
    // wait for spin to reach its angle, abort on timeout
    if (seq_step == STEP_SPIN_REACH) begin
      if (spin_ang > int'(reach_angle)) begin
        step_t0  = now;
        seq_step = STEP_SETTLE;
      end
      if (32'(now - step_t0) > reach_timeout) begin
        seq_step = STEP_IDLE;
        loads_aborted++;
      end
    end
    // settle, then reverse the belt with the gripper open
    if (seq_step == STEP_SETTLE) begin
      if (32'(now - step_t0) >= settle_us) begin
        step_t0   = now;
        belt_rev  = 1'b1;
        grip_hold = 1'b1;
        seq_step  = STEP_REVERSE;
      end
    end
    // stop the belt and close the gripper
    if (seq_step == STEP_REVERSE) begin
      if (32'(now - step_t0) >= reverse_us) begin
        step_t0   = now;
        belt_rev  = 1'b0;
        grip_hold = 1'b0;
        seq_step  = STEP_FINAL;
      end
    end
    // final pitch command and back to idle
    if (seq_step == STEP_FINAL) begin
      if (32'(now - step_t0) >= final_us) begin
        spin_hold       = 1'b1;
        r.pitch_cmd_out = FINAL_PITCH;
        seq_step        = STEP_IDLE;
        loads_done++;
      end
    end
    r.sequence_step = seq_step;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    if (fail_count < PRINT_LIMIT)
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (rst) begin
      home_timeout  = PITCH_HOME_TIMEOUT_RST;
      reach_timeout = SPIN_REACH_TIMEOUT_RST;
      settle_us     = SETTLE_DELAY_RST;
      reverse_us    = REVERSE_DURATION_RST;
      final_us      = FINAL_DELAY_RST;
      home_limit    = PITCH_HOME_LIMIT_RST;
      reach_angle   = SPIN_REACHED_ANGLE_RST;
      seq_step      = STEP_IDLE;
      step_t0       = '0;
      spin_hold     = 1'b0;
      belt_rev      = 1'b0;
      grip_hold     = 1'b0;
      expected_cmds.delete();
      fail_count    = 0;
      ticks_checked = 0;
      loads_done    = 0;
      loads_aborted = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_PITCH_HOME_TIMEOUT: home_timeout  = pwdata;
          REG_SPIN_REACH_TIMEOUT: reach_timeout = pwdata;
          REG_SETTLE_DELAY:       settle_us     = pwdata;
          REG_REVERSE_DURATION:   reverse_us    = pwdata;
          REG_FINAL_DELAY:        final_us      = pwdata;
          REG_PITCH_HOME_LIMIT:   home_limit    = pwdata[15:0];
          REG_SPIN_REACHED_ANGLE: reach_angle   = pwdata[15:0];
          default: ;
        endcase
      end
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_cmds.size() == 0) begin
          report_mismatch("result with no transaction pending", 40'(got), '0);
        end else begin
          want = expected_cmds.pop_front();
          ticks_checked++;
          if (got.pitch_cmd_out !== want.pitch_cmd_out)
            report_mismatch("pitch_cmd_out", 40'(got.pitch_cmd_out),
                            40'(want.pitch_cmd_out));
          if (got.spin_cmd_out !== want.spin_cmd_out)
            report_mismatch("spin_cmd_out", 40'(got.spin_cmd_out),
                            40'(want.spin_cmd_out));
          if (got.speed_cmd_out !== want.speed_cmd_out)
            report_mismatch("speed_cmd_out", 40'(got.speed_cmd_out),
                            40'(want.speed_cmd_out));
          if (got.gripper_drive !== want.gripper_drive)
            report_mismatch("gripper_drive", 40'(got.gripper_drive),
                            40'(want.gripper_drive));
          if (got.gripper_open !== want.gripper_open)
            report_mismatch("gripper_open", 40'(got.gripper_open),
                            40'(want.gripper_open));
          if (got.sequence_step !== want.sequence_step)
            report_mismatch("sequence_step", 40'(got.sequence_step),
                            40'(want.sequence_step));
        end
      end
      // input transaction
      if (in_valid && in_ready)
        expected_cmds.push_back(advance_loader(in_data));
    end
    pending = expected_cmds.size();
  end

endmodule

@@ verif/tb_ball_load_sequencer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ball_load_sequencer: testbench of the ball load sequencer
// Drives directed and random control ticks in bursts through several
// register settings, stalls the result side, and reports the checker verdict.
// ---------------------------------------------------------------------------
module tb_ball_load_sequencer;
  import bls_pkg::*;
  import bls_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [4:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int ticks_checked;
  int loads_done;
  int loads_aborted;

  int          burst_left    = 0;
  int          gap_left      = 0;
  logic [31:0] clock_us      = 32'd1000;
  int          home_lim      = 100;
  int          reach_ang     = 450;
  int          settings_used = 1;
  rx_mode_e    rx_mode       = RX_OPEN;
  int          rx_left       = 0;
  int          rx_phase      = 0;
  int          idle_cycles   = 0;

  always #5 clk = ~clk;

  ball_load_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  bls_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .ticks_checked(ticks_checked),
    .loads_done   (loads_done),
    .loads_aborted(loads_aborted)
  );

  // result side back-pressure; the mode is redrawn when its countdown runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(30, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= (rx_phase == 6) ? 0 : rx_phase + 1;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 99) < 55);
      default:   out_ready <= (rx_phase >= 3);
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ball_load_sequencer: mismatch");
      $finish;
    end
  end

  // one input transaction, sent in bursts with random gaps
  task automatic send_tick(input in_t t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
    end
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // directed tick, caller commands random
  task automatic drive(input logic req, input logic [31:0] now, input int pa, input int sa);
    in_t t;
    t.load_request      = req;
    t.pitch_cmd_in      = 16'($urandom);
    t.spin_cmd_in       = 1'($urandom);
    t.speed_cmd_in      = 16'($urandom);
    t.now_us            = now;
    t.pitch_motor_angle = 16'(pa);
    t.spin_motor_angle  = 16'(sa);
    send_tick(t);
  endtask

  // angle a little to one side of a threshold, clamped to 16 bits
  function automatic logic [15:0] near_angle(input int base, input int dir);
    int v;
    v = base + dir * int'($urandom_range(0, 40));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // random tick: time moves forward with rare jumps, angles mostly near thresholds
  task automatic random_tick(input int us_max, input int req_pct);
    in_t t;
    t.load_request = ($urandom_range(0, 99) < req_pct);
    t.pitch_cmd_in = 16'($urandom);
    t.spin_cmd_in  = 1'($urandom);
    t.speed_cmd_in = 16'($urandom);
    if ($urandom_range(0, 99) < 3)
      clock_us = $urandom;
    else
      clock_us = clock_us + $urandom_range(0, us_max);
    t.now_us = clock_us;
    if ($urandom_range(0, 9) == 0) begin
      t.pitch_motor_angle = 16'($urandom);
      t.spin_motor_angle  = 16'($urandom);
    end else begin
      t.pitch_motor_angle = ($urandom_range(0, 2) != 0) ? near_angle(-home_lim + 1, 1)
                                                        : near_angle(-home_lim, -1);
      t.spin_motor_angle  = ($urandom_range(0, 1) != 0) ? near_angle(reach_ang + 1, 1)
                                                        : near_angle(reach_ang, -1);
    end
    send_tick(t);
  endtask

  // stop sending and wait for every result to come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // setup then access cycle, bus left selected for the next write
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] home_to, input logic [31:0] reach_to,
                               input logic [31:0] settle, input logic [31:0] reverse,
                               input logic [31:0] fin, input int lim, input int ang);
    wait_idle();
    write_reg(REG_PITCH_HOME_TIMEOUT, home_to);
    write_reg(REG_SPIN_REACH_TIMEOUT, reach_to);
    write_reg(REG_SETTLE_DELAY, settle);
    write_reg(REG_REVERSE_DURATION, reverse);
    write_reg(REG_FINAL_DELAY, fin);
    write_reg(REG_PITCH_HOME_LIMIT, 32'(lim));
    write_reg(REG_SPIN_REACHED_ANGLE, 32'(ang));
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    home_lim  = lim;
    reach_ang = ang;
    settings_used++;
  endtask

  initial begin
    in_t t;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // idle pass-through at the extremes of the caller's commands
    t = {1'b0, 16'h7fff, 1'b1, 16'h8000, 32'd1000, 16'h0000, 16'h0000};
    send_tick(t);
    t = {1'b0, 16'h8000, 1'b0, 16'h7fff, 32'd1000, 16'h8000, 16'h7fff};
    send_tick(t);

    // pitch never home: holds at exactly the timeout, aborts one us later
    drive(1'b1, 32'd1000, -100, 0);
    drive(1'b0, 32'd1000 + PITCH_HOME_TIMEOUT_RST, -100, 0);
    drive(1'b0, 32'd1001 + PITCH_HOME_TIMEOUT_RST, -100, 0);

    // full load: home and reached in the request tick, then each delay edge
    drive(1'b1, 32'd5000000, -99, 451);
    drive(1'b0, 32'd5000000 + SETTLE_DELAY_RST - 1, 0, 0);
    drive(1'b1, 32'd5000000 + SETTLE_DELAY_RST, 0, 0);
    drive(1'b0, 32'd5100000 + REVERSE_DURATION_RST - 1, 0, 0);
    drive(1'b1, 32'd5100000 + REVERSE_DURATION_RST, 0, 0);
    drive(1'b0, 32'd6600000 + FINAL_DELAY_RST, 0, 0);

    // spin never reached: holds at exactly the timeout, then aborts
    drive(1'b1, 32'd8000000, -99, 450);
    drive(1'b0, 32'd8000000 + SPIN_REACH_TIMEOUT_RST, 0, 450);
    drive(1'b0, 32'd8000001 + SPIN_REACH_TIMEOUT_RST, 0, 450);

    // elapsed time across the 32-bit wrap
    drive(1'b1, 32'hffff_fff0, 0, 0);
    drive(1'b0, 32'h0000_0010, 0, 1000);
    drive(1'b0, 32'h0000_0010 + SETTLE_DELAY_RST, 0, 0);
    clock_us = 32'h0000_0010 + SETTLE_DELAY_RST;

    // all delays zero: whole sequence can cascade in one tick
    load_settings('0, '0, '0, '0, '0, 0, 0);
    repeat (120) random_tick(50, 30);

    // short delays with default thresholds
    load_settings(32'd3000, 32'd3000, 32'd150, 32'd600, 32'd300,
                  int'(PITCH_HOME_LIMIT_RST), int'(SPIN_REACHED_ANGLE_RST));
    repeat (160) random_tick(200, 25);

    // timeouts at full scale, thresholds that almost always pass
    load_settings('1, '1, 32'd40, 32'd80, 32'd60, 32767, -32768);
    repeat (100) random_tick(30, 25);

    // thresholds that never pass, short timeouts
    load_settings(32'd100, 32'd100, 32'd20, 32'd20, 32'd20, -32768, 32767);
    repeat (80) random_tick(60, 40);

    // every time register at full scale
    load_settings('1, '1, '1, '1, '1,
                  int'(PITCH_HOME_LIMIT_RST), int'(SPIN_REACHED_ANGLE_RST));
    repeat (40) random_tick(1000, 30);

    // random settings, some starting just below the time wrap
    repeat (3) begin
      load_settings($urandom_range(0, 4000), $urandom_range(0, 4000),
                    $urandom_range(0, 800), $urandom_range(0, 800), $urandom_range(0, 800),
                    int'($urandom_range(0, 1200)) - 600, int'($urandom_range(0, 1200)) - 600);
      clock_us = ($urandom_range(0, 1) != 0) ? 32'hffff_f000 : $urandom;
      repeat (90) random_tick(150, 25);
    end

    wait_idle();
    $display("run covered %0d ticks under %0d register settings, zero and full-scale delays",
             ticks_checked, settings_used);
    $display("loads completed %0d, aborted on timeout %0d, field errors %0d",
             loads_done, loads_aborted, fail_count);
    if (fail_count == 0)
      $display("ball_load_sequencer: match");
    else
      $display("ball_load_sequencer: mismatch");
    $finish;
  end

endmodule

@@ ball_load_sequencer.f @@
rtl/core/bls_pkg.sv
rtl/core/ball_load_sequencer.sv
verif/bls_tb_pkg.sv
verif/bls_checker.sv
verif/tb_ball_load_sequencer.sv
